// ===== rtl/srvm_pkg.sv =====
// Shared types and constants for the stack/register machine executor.
// No dependencies; every other file but srvm_ram refers to this package by scoped names.
`default_nettype none

package srvm_pkg;

  localparam int WORD_W      = 32;
  localparam int STACK_DEPTH = 256;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  localparam int NREGS     = 9;
  localparam int REG_IDX_W = $clog2(NREGS);
  localparam int REG_A     = 1;
  localparam int REG_B     = 2;
  localparam int REG_PC    = 7;
  localparam int REG_SP    = 8;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    OP_HALT     = 4'd0,
    OP_PUSH     = 4'd1,
    OP_POP      = 4'd2,
    OP_ADD      = 4'd3,
    OP_STORE    = 4'd4,
    OP_REGADD   = 4'd5,
    OP_SHOW     = 4'd6,
    OP_MOVE     = 4'd7,
    OP_EXCHANGE = 4'd8,
    OP_AND      = 4'd9,
    OP_OR       = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_HALT = 3'd1,
    EV_POP  = 3'd2,
    EV_SUM  = 3'd3,
    EV_SHOW = 3'd4,
    EV_AND  = 3'd5,
    EV_OR   = 3'd6
  } event_t;

endpackage

`default_nettype wire

// ===== rtl/stack_register_vm_executor_core.sv =====
// Top level of the stack/register machine executor: input register, execute logic,
// register file, stack RAM (srvm_ram) and result register. Uses srvm_pkg.
//
//   Channel | Ports                                            | Direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid, in_ready, in_command, in_operand_a/b   | in
//   result  | out_valid, out_ready, out_next_pc, out_value,    | out
//           | out_event_res, out_halted, out_fault             |
//
// One instruction is executed per cycle while the result register is free or is
// being emptied; a request is held in the input register and, once it executes, is
// written to the result register. The input register serves the stack RAM read:
// its address is issued from the next stack pointer at the edge before an
// instruction executes. Reset clears the register file (stack pointer to minus one),
// the halt flag and the handshake state; the stack RAM is not cleared.
// A stalled result holds its register while one more request waits at the input.
`default_nettype none

module stack_register_vm_executor_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_command,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_next_pc,
  output logic signed [31:0] out_value,
  output logic [2:0]       out_event_res,
  output logic             out_halted,
  output logic             out_fault
);

  localparam int AW = srvm_pkg::STACK_AW;

  // Input register: holds one request until the execute logic takes it.
  logic                in_v_r;
  logic [3:0]          cmd_r;
  srvm_pkg::word_t     opa_r;
  srvm_pkg::word_t     opb_r;

  // Architectural state.
  srvm_pkg::word_t     regs_r [0:srvm_pkg::NREGS-1];
  srvm_pkg::word_t     regs_nxt [0:srvm_pkg::NREGS-1];
  logic                halt_r;
  logic                halt_nxt;

  // Result register.
  logic                out_v_r;
  srvm_pkg::word_t     pc_out_r;
  srvm_pkg::word_t     val_out_r;
  logic [2:0]          ev_out_r;
  logic                halted_out_r;
  logic                fault_out_r;

  // Execute results.
  srvm_pkg::word_t     val_nxt;
  srvm_pkg::event_t    ev_nxt;
  logic                fault_nxt;

  // Stack RAM signals and write forwarding.
  logic                st_we;
  logic [AW-1:0]       st_waddr;
  srvm_pkg::word_t     st_wdata;
  logic [AW-1:0]       st_raddr0;
  logic [AW-1:0]       st_raddr1;
  srvm_pkg::word_t     st_rdata0;
  srvm_pkg::word_t     st_rdata1;
  logic                fwd0_r;
  logic                fwd1_r;
  srvm_pkg::word_t     fwd_data_r;
  srvm_pkg::word_t     stk_top;
  srvm_pkg::word_t     stk_nos;
  srvm_pkg::word_t     sp_nxt;
  srvm_pkg::word_t     sp_nxt_m1;

  logic                exec;

  // The instruction in the input register executes whenever the result register
  // is free or is being emptied in this cycle.
  assign exec     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      opa_r <= in_operand_a;
      opb_r <= in_operand_b;
    end
  end

  // The stack RAM holds data read at the stack pointer that was current at the
  // previous edge; a write made at that same edge is taken from the forward copy.
  assign stk_top = fwd0_r ? fwd_data_r : st_rdata0;
  assign stk_nos = fwd1_r ? fwd_data_r : st_rdata1;

  // Execute logic. Register updates are applied in the same order as the
  // machine defines them, so writes to PC or SP interact with the increments.
  always_comb begin
    srvm_pkg::word_t             t [0:srvm_pkg::NREGS-1];
    srvm_pkg::word_t             tmp;
    srvm_pkg::word_t             sp;
    srvm_pkg::word_t             sp_p1;
    srvm_pkg::word_t             sp_m1;
    logic signed [31:0]          sp_s;
    logic                        a_ok;
    logic                        b_ok;
    logic [srvm_pkg::REG_IDX_W-1:0] ia;
    logic [srvm_pkg::REG_IDX_W-1:0] ib;

    t         = regs_r;
    sp        = regs_r[srvm_pkg::REG_SP];
    sp_s      = signed'(sp);
    sp_p1     = sp + 32'd1;
    sp_m1     = sp - 32'd1;
    a_ok      = opa_r < 32'(srvm_pkg::NREGS);
    b_ok      = opb_r < 32'(srvm_pkg::NREGS);
    ia        = opa_r[srvm_pkg::REG_IDX_W-1:0];
    ib        = opb_r[srvm_pkg::REG_IDX_W-1:0];
    tmp       = '0;
    halt_nxt  = halt_r;
    val_nxt   = '0;
    ev_nxt    = srvm_pkg::EV_NONE;
    fault_nxt = 1'b0;
    st_we     = 1'b0;
    st_waddr  = sp_p1[AW-1:0];
    st_wdata  = opa_r;

    if (!halt_r) begin
      case (srvm_pkg::op_t'(cmd_r))
        srvm_pkg::OP_HALT: begin
          halt_nxt = 1'b1;
          ev_nxt   = srvm_pkg::EV_HALT;
          t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
        end
        srvm_pkg::OP_PUSH: begin
          if (sp_s < -32'sd1 || sp_s > signed'(32'(srvm_pkg::STACK_DEPTH - 2))) begin
            fault_nxt = 1'b1;
          end else begin
            t[srvm_pkg::REG_SP] = sp_p1;
            st_we    = 1'b1;
            st_waddr = sp_p1[AW-1:0];
            st_wdata = opa_r;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd2;
          end
        end
        srvm_pkg::OP_POP: begin
          if (sp_s < 32'sd0 || sp_s > signed'(32'(srvm_pkg::STACK_DEPTH - 1))) begin
            fault_nxt = 1'b1;
          end else begin
            val_nxt = stk_top;
            ev_nxt  = srvm_pkg::EV_POP;
            t[srvm_pkg::REG_SP] = sp_m1;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_ADD: begin
          if (sp_s < 32'sd1 || sp_s > signed'(32'(srvm_pkg::STACK_DEPTH - 1))) begin
            fault_nxt = 1'b1;
          end else begin
            tmp     = stk_nos + stk_top;
            val_nxt = tmp;
            ev_nxt  = srvm_pkg::EV_SUM;
            t[srvm_pkg::REG_A]  = stk_top;
            t[srvm_pkg::REG_B]  = tmp;
            st_we    = 1'b1;
            st_waddr = sp_m1[AW-1:0];
            st_wdata = tmp;
            t[srvm_pkg::REG_SP] = sp_m1;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_STORE: begin
          if (!a_ok) begin
            fault_nxt = 1'b1;
          end else begin
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd2;
            t[ia] = opb_r;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_REGADD: begin
          if (!a_ok || !b_ok) begin
            fault_nxt = 1'b1;
          end else begin
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd2;
            t[ia]   = t[ia] + t[ib];
            val_nxt = t[ia];
            ev_nxt  = srvm_pkg::EV_SUM;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_SHOW: begin
          if (!a_ok) begin
            fault_nxt = 1'b1;
          end else begin
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
            val_nxt = t[ia];
            ev_nxt  = srvm_pkg::EV_SHOW;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_MOVE: begin
          if (!a_ok || !b_ok) begin
            fault_nxt = 1'b1;
          end else begin
            t[ib] = t[ia];
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd3;
          end
        end
        srvm_pkg::OP_EXCHANGE: begin
          if (!a_ok || !b_ok) begin
            fault_nxt = 1'b1;
          end else begin
            tmp   = t[ib];
            t[ib] = t[ia];
            t[ia] = tmp;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd3;
          end
        end
        srvm_pkg::OP_AND, srvm_pkg::OP_OR: begin
          if (!a_ok || !b_ok) begin
            fault_nxt = 1'b1;
          end else begin
            if (srvm_pkg::op_t'(cmd_r) == srvm_pkg::OP_AND) begin
              tmp    = t[ia] & t[ib];
              ev_nxt = srvm_pkg::EV_AND;
            end else begin
              tmp    = t[ia] | t[ib];
              ev_nxt = srvm_pkg::EV_OR;
            end
            val_nxt = tmp;
            t[ia]   = tmp;
            t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd3;
          end
        end
        default: begin
          // Unused opcodes only step past themselves.
          t[srvm_pkg::REG_PC] = t[srvm_pkg::REG_PC] + 32'd1;
        end
      endcase
    end

    // A faulting instruction leaves all state as it was.
    if (fault_nxt) begin
      t = regs_r;
    end
    regs_nxt = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < srvm_pkg::NREGS; i++) begin
        if (i == srvm_pkg::REG_SP) begin
          regs_r[i] <= '1;
        end else begin
          regs_r[i] <= '0;
        end
      end
      halt_r <= 1'b0;
    end else if (exec) begin
      regs_r <= regs_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Stack RAM read addresses follow the stack pointer that the next instruction
  // will see, so its top two entries are waiting when it executes.
  assign sp_nxt    = exec ? regs_nxt[srvm_pkg::REG_SP] : regs_r[srvm_pkg::REG_SP];
  assign sp_nxt_m1 = sp_nxt - 32'd1;
  assign st_raddr0 = sp_nxt[AW-1:0];
  assign st_raddr1 = sp_nxt_m1[AW-1:0];

  srvm_ram #(
    .WIDTH(srvm_pkg::WORD_W),
    .DEPTH(srvm_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (st_we && exec),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr0(st_raddr0),
    .raddr1(st_raddr1),
    .rdata0(st_rdata0),
    .rdata1(st_rdata1)
  );

  // The RAM returns old data on a read that collides with a write, so the
  // written word is kept aside for the following instruction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd0_r <= 1'b0;
      fwd1_r <= 1'b0;
    end else begin
      fwd0_r <= st_we && exec && (st_waddr == st_raddr0);
      fwd1_r <= st_we && exec && (st_waddr == st_raddr1);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= st_wdata;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (exec) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      pc_out_r     <= regs_nxt[srvm_pkg::REG_PC];
      val_out_r    <= val_nxt;
      ev_out_r     <= ev_nxt;
      halted_out_r <= halt_nxt;
      fault_out_r  <= fault_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_next_pc   = signed'(pc_out_r);
  assign out_value     = signed'(val_out_r);
  assign out_event_res = ev_out_r;
  assign out_halted    = halted_out_r;
  assign out_fault     = fault_out_r;

endmodule

`default_nettype wire

// ===== rtl/srvm_ram.sv =====
// Generic RAM: one write port, two registered read ports, read returns old data.
// No dependencies.
`default_nettype none

module srvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ===== rtl/srvm_checker.sv =====
// Port-level checker for the stack/register machine executor, with its bind.
// Uses srvm_pkg; attaches to stack_register_vm_executor_core.
`default_nettype none

module srvm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_next_pc,
  input wire logic [31:0] out_value,
  input wire logic [2:0]  out_event_res,
  input wire logic        out_halted,
  input wire logic        out_fault
);

  logic seen_halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && out_halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_value)
      && $stable(out_event_res) && $stable(out_halted) && $stable(out_fault))
    else $error("stalled result changed");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_value == '0 && out_event_res == srvm_pkg::EV_NONE)
    else $error("faulting result carries a value or event");

  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == srvm_pkg::EV_HALT |-> out_halted && !out_fault)
    else $error("halt result without halted flag");

  a_after_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |-> out_halted && !out_fault && out_value == '0
      && out_event_res == srvm_pkg::EV_NONE)
    else $error("result after halt is not idle");

endmodule

bind stack_register_vm_executor_core srvm_checker u_srvm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_next_pc  (out_next_pc),
  .out_value    (out_value),
  .out_event_res(out_event_res),
  .out_halted   (out_halted),
  .out_fault    (out_fault)
);

`default_nettype wire

// ===== tb/stack_register_vm_executor_core_test.sv =====
// Self-checking testbench for stack_register_vm_executor_core.
// Depends on srvm_pkg for the opcode, event and machine-size constants, and on the RTL alone.
// A behavioural copy of the machine predicts every result, which is checked in order.

module stack_register_vm_executor_core_test;

  // The long hold-off on the result side, and the number of quiet cycles after which
  // the run is declared hung. The hold-off is far below the limit.
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int N_RANDOM     = 860;
  localparam int N_PHASES     = 5;

  // One request as the block sees it, one result, and the whole architectural state.
  // The written mask is not part of the machine: it lets the stimulus keep clear of
  // stack words that have never been written.
  typedef struct packed {
    logic [3:0]      cmd;
    srvm_pkg::word_t a;
    srvm_pkg::word_t b;
  } request_t;

  typedef struct packed {
    srvm_pkg::word_t next_pc;
    srvm_pkg::word_t value;
    logic [2:0]      ev;
    logic            halted;
    logic            fault;
  } result_t;

  typedef struct packed {
    logic [srvm_pkg::NREGS-1:0][srvm_pkg::WORD_W-1:0]       regs;
    logic [srvm_pkg::STACK_DEPTH-1:0][srvm_pkg::WORD_W-1:0] stack_words;
    logic [srvm_pkg::STACK_DEPTH-1:0]                       written;
    logic                                                   halted;
  } machine_t;

  typedef struct packed {
    machine_t m;
    result_t  r;
  } machine_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_command = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_next_pc;
  logic signed [31:0] out_value;
  logic [2:0]         out_event_res;
  logic               out_halted;
  logic               out_fault;

  // plan_state runs ahead while the stimulus is built; exec_state advances only as the
  // block accepts requests, and is the one the results are checked against.
  machine_t  plan_state;
  machine_t  exec_state;
  request_t  pending_requests[$];
  result_t   expected_results[$];
  request_t  offered;
  machine_step_t advanced;

  int total_requests = 1;
  int n_sent = 0;
  int n_results = 0;
  int n_faults = 0;
  int n_errors = 0;
  int phase = 0;
  int hold_left = 0;
  bit held_off = 1'b0;
  int quiet_cycles = 0;

  stack_register_vm_executor_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_pc   (out_next_pc),
    .out_value     (out_value),
    .out_event_res (out_event_res),
    .out_halted    (out_halted),
    .out_fault     (out_fault)
  );

  always #5 clk = ~clk;

  // Executes one instruction on a copy of the machine and returns the new state along
  // with the result the block must report. A fault leaves the state untouched, and a
  // halted machine ignores everything.
  function automatic machine_step_t execute_instruction(machine_t m, request_t q);
    machine_step_t   s;
    int              sp;
    srvm_pkg::word_t t;
    srvm_pkg::word_t v;
    logic [2:0]      ev;
    logic            flt;
    logic [3:0]      ra;
    logic [3:0]      rb;
    logic            bad_a;
    logic            bad_b;
    v     = '0;
    ev    = srvm_pkg::EV_NONE;
    flt   = 1'b0;
    sp    = $signed(m.regs[srvm_pkg::REG_SP]);
    bad_a = q.a >= srvm_pkg::NREGS;
    bad_b = q.b >= srvm_pkg::NREGS;
    ra    = q.a[3:0];
    rb    = q.b[3:0];
    if (!m.halted) begin
      case (q.cmd)
        srvm_pkg::OP_HALT: begin
          m.halted = 1'b1;
          ev = srvm_pkg::EV_HALT;
          m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
        end
        srvm_pkg::OP_PUSH: begin
          if (sp < -1 || sp > srvm_pkg::STACK_DEPTH - 2) begin
            flt = 1'b1;
          end else begin
            m.regs[srvm_pkg::REG_SP] = sp + 1;
            m.stack_words[sp + 1] = q.a;
            m.written[sp + 1] = 1'b1;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd2;
          end
        end
        srvm_pkg::OP_POP: begin
          if (sp < 0 || sp > srvm_pkg::STACK_DEPTH - 1) begin
            flt = 1'b1;
          end else begin
            v = m.stack_words[sp];
            m.regs[srvm_pkg::REG_SP] = sp - 1;
            ev = srvm_pkg::EV_POP;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_ADD: begin
          if (sp < 1 || sp > srvm_pkg::STACK_DEPTH - 1) begin
            flt = 1'b1;
          end else begin
            t = m.stack_words[sp];
            m.regs[srvm_pkg::REG_A] = t;
            v = m.stack_words[sp - 1] + t;
            m.regs[srvm_pkg::REG_B] = v;
            m.stack_words[sp - 1] = v;
            m.regs[srvm_pkg::REG_SP] = sp - 1;
            ev = srvm_pkg::EV_SUM;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_STORE: begin
          if (bad_a) begin
            flt = 1'b1;
          end else begin
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd2;
            m.regs[ra] = q.b;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_REGADD: begin
          if (bad_a || bad_b) begin
            flt = 1'b1;
          end else begin
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd2;
            m.regs[ra] = m.regs[ra] + m.regs[rb];
            v = m.regs[ra];
            ev = srvm_pkg::EV_SUM;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_SHOW: begin
          if (bad_a) begin
            flt = 1'b1;
          end else begin
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
            v = m.regs[ra];
            ev = srvm_pkg::EV_SHOW;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
          end
        end
        srvm_pkg::OP_MOVE: begin
          if (bad_a || bad_b) begin
            flt = 1'b1;
          end else begin
            m.regs[rb] = m.regs[ra];
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd3;
          end
        end
        srvm_pkg::OP_EXCHANGE: begin
          if (bad_a || bad_b) begin
            flt = 1'b1;
          end else begin
            t = m.regs[rb];
            m.regs[rb] = m.regs[ra];
            m.regs[ra] = t;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd3;
          end
        end
        srvm_pkg::OP_AND, srvm_pkg::OP_OR: begin
          if (bad_a || bad_b) begin
            flt = 1'b1;
          end else begin
            if (q.cmd == srvm_pkg::OP_AND) begin
              v = m.regs[ra] & m.regs[rb];
              ev = srvm_pkg::EV_AND;
            end else begin
              v = m.regs[ra] | m.regs[rb];
              ev = srvm_pkg::EV_OR;
            end
            m.regs[ra] = v;
            m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd3;
          end
        end
        default: begin
          m.regs[srvm_pkg::REG_PC] = m.regs[srvm_pkg::REG_PC] + 32'd1;
        end
      endcase
    end
    s.m         = m;
    s.r.next_pc = m.regs[srvm_pkg::REG_PC];
    s.r.value   = v;
    s.r.ev      = ev;
    s.r.halted  = m.halted;
    s.r.fault   = flt;
    return s;
  endfunction

  // Operand words lean towards the extremes of the signed range.
  function automatic srvm_pkg::word_t random_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a valid register index; now and then one just past the file or a huge one,
  // negative values included, to provoke the bad-index fault.
  function automatic srvm_pkg::word_t reg_index();
    if ($urandom_range(0, 7) != 0) return $urandom_range(0, srvm_pkg::NREGS - 1);
    if ($urandom_range(0, 1) != 0) return $urandom_range(srvm_pkg::NREGS, 15);
    return $urandom | 32'h0000_0010;
  endfunction

  // Share of cycles in which a side idles, by phase: first no idling, then the sender
  // alone, then the receiver alone, then both at half the rate, then none again.
  function automatic int idle_percent(int ph, bit receiver);
    if (ph == 3) return 28;
    if (ph == 1 && !receiver) return 56;
    if (ph == 2 && receiver) return 56;
    return 0;
  endfunction

  // Queues a request and advances the planning copy, so that later choices can see
  // where the stack pointer stands and which stack words hold data.
  task automatic offer(input logic [3:0] cmd, input srvm_pkg::word_t a,
                       input srvm_pkg::word_t b);
    request_t      q;
    machine_step_t s;
    q.cmd = cmd;
    q.a   = a;
    q.b   = b;
    s = execute_instruction(plan_state, q);
    plan_state = s.m;
    pending_requests.push_back(q);
  endtask

  // Driver. A request, once offered, is held until accepted; the prediction is made at
  // the edge of acceptance, so the expectation store follows the block exactly.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advanced = execute_instruction(exec_state, offered);
        exec_state = advanced.m;
        expected_results.push_back(advanced.r);
        n_sent = n_sent + 1;
        phase <= (n_sent * N_PHASES) / total_requests;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 &&
            $urandom_range(0, 99) >= idle_percent(phase, 1'b0)) begin
          offered = pending_requests.pop_front();
          in_valid     <= 1'b1;
          in_command   <= offered.cmd;
          in_operand_a <= offered.a;
          in_operand_b <= offered.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. On entering the last phase it holds off for a long stretch while the
  // sender keeps offering, so the result register fills and the input must stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == N_PHASES - 1 && !held_off) begin
      held_off  <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= idle_percent(phase, 1'b1);
    end
  end

  // Monitor. Each accepted result is compared with the oldest expectation; the first
  // ten problems are reported in full and the rest only counted.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        n_errors = n_errors + 1;
        if (n_errors <= 10)
          $display("unexpected result: pc=%h value=%h ev=%0d halted=%b fault=%b",
                   out_next_pc, out_value, out_event_res, out_halted, out_fault);
      end else begin
        exp_r = expected_results.pop_front();
        n_results = n_results + 1;
        if (exp_r.fault) n_faults = n_faults + 1;
        if (out_next_pc !== exp_r.next_pc || out_value !== exp_r.value ||
            out_event_res !== exp_r.ev || out_halted !== exp_r.halted ||
            out_fault !== exp_r.fault) begin
          n_errors = n_errors + 1;
          if (n_errors <= 10)
            $display("result %0d mismatch: expected pc=%h value=%h ev=%0d h=%b f=%b, %s",
                     n_results, exp_r.next_pc, exp_r.value, exp_r.ev, exp_r.halted,
                     exp_r.fault,
                     $sformatf("got pc=%h value=%h ev=%0d h=%b f=%b", out_next_pc,
                               out_value, out_event_res, out_halted, out_fault));
        end
      end
    end
  end

  // Watchdog: a run in which neither channel moves for too long has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int              n;
    int              pick;
    int              sp;
    logic [3:0]      cmd;
    srvm_pkg::word_t a;
    srvm_pkg::word_t b;

    // Both copies of the machine start from the reset state: registers clear, stack
    // pointer at minus one, nothing written, not halted.
    plan_state = '0;
    plan_state.regs[srvm_pkg::REG_SP] = '1;
    exec_state = plan_state;

    // Directed opening: stack underflow from reset, add with too few words, a wrapping
    // sum, extreme operand values, bad indices of either sign, every register operation,
    // showing the program counter (which has already moved on), unused opcodes, stack
    // overflow at the top and a program counter that wraps to zero.
    offer(srvm_pkg::OP_POP, 32'h1234_5678, 32'h0);
    offer(srvm_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF);
    offer(srvm_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h0);
    offer(srvm_pkg::OP_ADD, 32'h0, 32'h0);
    offer(srvm_pkg::OP_PUSH, 32'h0000_0001, 32'h0);
    offer(srvm_pkg::OP_ADD, 32'h0, 32'h0);
    offer(srvm_pkg::OP_POP, 32'h0, 32'h0);
    offer(srvm_pkg::OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF);
    offer(srvm_pkg::OP_STORE, srvm_pkg::REG_A, 32'h7FFF_FFFF);
    offer(srvm_pkg::OP_STORE, srvm_pkg::NREGS, 32'h5555_5555);
    offer(srvm_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h1);
    offer(srvm_pkg::OP_REGADD, srvm_pkg::REG_A, srvm_pkg::REG_A);
    offer(srvm_pkg::OP_REGADD, srvm_pkg::REG_A, 32'h8000_0000);
    offer(srvm_pkg::OP_SHOW, srvm_pkg::REG_PC, 32'h0);
    offer(srvm_pkg::OP_SHOW, srvm_pkg::REG_SP, 32'h0);
    offer(srvm_pkg::OP_MOVE, srvm_pkg::REG_A, 32'd3);
    offer(srvm_pkg::OP_MOVE, srvm_pkg::REG_B, 32'd12);
    offer(srvm_pkg::OP_EXCHANGE, srvm_pkg::REG_A, 32'd3);
    offer(srvm_pkg::OP_AND, srvm_pkg::REG_A, srvm_pkg::REG_SP);
    offer(srvm_pkg::OP_OR, 32'd3, 32'd0);
    offer(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(4'd15, 32'h0, 32'h0);
    offer(srvm_pkg::OP_STORE, srvm_pkg::REG_SP, srvm_pkg::STACK_DEPTH - 1);
    offer(srvm_pkg::OP_PUSH, 32'hDEAD_BEEF, 32'h0);
    offer(srvm_pkg::OP_STORE, srvm_pkg::REG_SP, 32'h0);
    offer(srvm_pkg::OP_STORE, srvm_pkg::REG_PC, 32'hFFFF_FFFF);

    // Random part. Stack reads are steered away from words that were never written;
    // a wild stack pointer is brought back now and then so the stack stays in use.
    for (n = 0; n < N_RANDOM; n++) begin
      sp = $signed(plan_state.regs[srvm_pkg::REG_SP]);
      if ($urandom_range(0, 149) == 0) begin
        // Climb to the very top of the stack, overflow once, then read back down.
        offer(srvm_pkg::OP_STORE, srvm_pkg::REG_SP, srvm_pkg::STACK_DEPTH - 7);
        repeat (7) offer(srvm_pkg::OP_PUSH, random_word(), $urandom);
        offer(srvm_pkg::OP_POP, $urandom, $urandom);
        offer(srvm_pkg::OP_POP, $urandom, $urandom);
        offer(srvm_pkg::OP_ADD, $urandom, $urandom);
      end else if ((sp < -1 || sp > srvm_pkg::STACK_DEPTH - 1) &&
                   $urandom_range(0, 3) == 0) begin
        offer(srvm_pkg::OP_STORE, srvm_pkg::REG_SP, $urandom_range(0, 8) - 1);
      end else begin
        pick = $urandom_range(0, 99);
        a = $urandom;
        b = $urandom;
        if (pick < 22) begin
          cmd = srvm_pkg::OP_PUSH;
          a = random_word();
        end else if (pick < 34) begin
          cmd = srvm_pkg::OP_POP;
        end else if (pick < 44) begin
          cmd = srvm_pkg::OP_ADD;
        end else if (pick < 54) begin
          cmd = srvm_pkg::OP_STORE;
          a = reg_index();
          if (a == srvm_pkg::REG_SP && $urandom_range(0, 2) != 0)
            b = $urandom_range(0, srvm_pkg::STACK_DEPTH + 1) - 1;
          else
            b = random_word();
        end else if (pick < 96) begin
          case (pick % 6)
            0:       cmd = srvm_pkg::OP_REGADD;
            1:       cmd = srvm_pkg::OP_SHOW;
            2:       cmd = srvm_pkg::OP_MOVE;
            3:       cmd = srvm_pkg::OP_EXCHANGE;
            4:       cmd = srvm_pkg::OP_AND;
            default: cmd = srvm_pkg::OP_OR;
          endcase
          a = reg_index();
          b = reg_index();
        end else begin
          cmd = 4'($urandom_range(11, 15));
        end
        if (cmd == srvm_pkg::OP_POP && sp >= 0 && sp < srvm_pkg::STACK_DEPTH &&
            !plan_state.written[sp])
          cmd = srvm_pkg::OP_PUSH;
        if (cmd == srvm_pkg::OP_ADD && sp >= 1 && sp < srvm_pkg::STACK_DEPTH &&
            !(plan_state.written[sp] && plan_state.written[sp - 1]))
          cmd = srvm_pkg::OP_PUSH;
        offer(cmd, a, b);
      end
    end

    // Halt last of all, then a few requests that a halted machine must ignore.
    offer(srvm_pkg::OP_HALT, $urandom, $urandom);
    offer(srvm_pkg::OP_PUSH, 32'h1, 32'h0);
    offer(srvm_pkg::OP_POP, 32'h0, 32'h0);
    offer(srvm_pkg::OP_STORE, srvm_pkg::REG_PC, 32'h0);
    offer(srvm_pkg::OP_SHOW, srvm_pkg::REG_PC, 32'h0);
    offer(4'd13, 32'h0, 32'h0);
    offer(srvm_pkg::OP_HALT, 32'h0, 32'h0);
    total_requests = pending_requests.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every result to come out, then give the
    // input and result registers room to show any stray result.
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests executed and %0d results checked, %0d of them faults;",
             n_sent, n_results, n_faults);
    $display("five handshake phases ran, one with an %0d-cycle hold-off on the results.",
             HOLD_CYCLES);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d errors", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
